// ===== hw/rtl/blink_pkg.sv =====
// ----------------------------------------------------------------------------
// blink_pkg
// Shared types and constants for the multi-channel LED blinker core.
// ----------------------------------------------------------------------------
`default_nettype none

package blink_pkg;

  localparam int CHANNELS = 8;
  localparam int CHAN_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = 1;
  localparam int QCNT_W   = 2;

  typedef enum logic [1:0] {
    OP_START     = 2'd0,
    OP_SET_COUNT = 2'd1,
    OP_TICK      = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  pin;
    logic        active_level;
    logic [15:0] repeat_count;
    logic [15:0] on_time;
    logic [15:0] off_time;
  } request_t;

  typedef struct packed {
    logic       drive_valid;
    logic [7:0] drive_pin;
    logic       drive_level;
    logic       status;
    logic       last;
  } result_t;

  typedef struct packed {
    logic     valid;
    request_t item;
  } queue_head_t;

endpackage

`default_nettype wire

// ===== hw/rtl/multi_channel_led_blinker_core.sv =====
// ----------------------------------------------------------------------------
// multi_channel_led_blinker_core
// Table of blink channels driving output pins through timed on/off cycles.
//
//   port group   direction  handshake
//   request      in         start / busy, taken when start & !busy
//   result       out        one-cycle strobe, cannot be held off
//   tick_period  in         cfg_we / cfg_wdata, written on cfg_we
//
// A start or set-count request is queued, then strobed from the result
// register once the back end is idle. A tick walks all channels, one
// channel read per cycle; each drive is held until the next one or the end
// of the walk, and the last one is strobed from the flush state.
// busy is high while the two-entry queue is full; the receiver cannot stall.
// Reset empties the queue, disables all channels and sets tick_period to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_led_blinker_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire blink_pkg::request_t request,
  input  wire logic                cfg_we,
  input  wire logic [15:0]         cfg_wdata,
  output logic                     strobe,
  output blink_pkg::result_t       result
);
  import blink_pkg::*;

  queue_head_t head;
  logic        pop;
  logic [15:0] tick_period;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period <= 16'd1;
    end else if (cfg_we) begin
      tick_period <= cfg_wdata;
    end
  end

  blink_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .head    (head),
    .pop     (pop)
  );

  blink_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .tick_period (tick_period),
    .strobe      (strobe),
    .result      (result)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/blink_front.sv =====
// ----------------------------------------------------------------------------
// blink_front
// Accepts requests, drops unused op codes and queues the rest for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module blink_front (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire blink_pkg::request_t    request,
  output blink_pkg::queue_head_t      head,
  input  wire logic                   pop
);
  import blink_pkg::*;

  request_t            q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                push;
  logic                do_pop;

  assign busy   = (count == QCNT_W'(QDEPTH));
  assign push   = start && !busy && (op_t'(request.op) != OP_NONE);
  assign do_pop = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.item  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= request;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |=> (count == '0) || (count == QCNT_W'(1)))
    else $error("queue count jumped from empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue overflow");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/blink_back.sv =====
// ----------------------------------------------------------------------------
// blink_back
// Channel table and executor: start and set-count lookups, and the tick walk
// over all channels with a two-stage read / update pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module blink_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire blink_pkg::queue_head_t head,
  output logic                        pop,
  input  wire logic [15:0]            tick_period,
  output logic                        strobe,
  output blink_pkg::result_t          result
);
  import blink_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DRIVE_ON = 2'd1,
    PH_WAIT_ON  = 2'd2,
    PH_WAIT_OFF = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FLUSH
  } state_t;

  localparam logic [CHAN_W-1:0] LAST_IDX = CHAN_W'(CHANNELS - 1);

  logic [7:0]   chan_pin      [CHANNELS];
  logic         chan_level    [CHANNELS];
  logic [15:0]  chan_count    [CHANNELS];
  logic [15:0]  chan_on_time  [CHANNELS];
  logic [15:0]  chan_off_time [CHANNELS];
  logic         chan_enabled  [CHANNELS];
  phase_t       chan_phase    [CHANNELS];
  logic [31:0]  chan_stamp    [CHANNELS];
  logic [31:0]  tick_counter;

  state_t       state;
  logic [CHAN_W-1:0] idx;

  // read stage
  logic              s1_valid;
  logic [CHAN_W-1:0] s1_idx;
  logic [7:0]        s1_pin;
  logic              s1_level;
  logic [15:0]       s1_count;
  logic [15:0]       s1_on;
  logic [15:0]       s1_off;
  logic              s1_enabled;
  phase_t            s1_phase;
  logic [47:0]       s1_prod;

  // held drive, sent once the next one or the end of the walk is known
  logic              hold_valid;
  logic [7:0]        hold_pin;
  logic              hold_level;

  // lookup
  logic              match_found;
  logic [CHAN_W-1:0] match_idx;
  logic              free_found;
  logic [CHAN_W-1:0] free_idx;
  logic [31:0]       diff;
  logic [47:0]       prod;

  // update stage
  logic              s2_drive;
  logic              s2_drive_level;
  logic              s2_restamp;
  logic              s2_dec;
  logic              s2_set_phase;
  phase_t            s2_phase_next;
  logic [31:0]       elapsed;

  assign pop = (state == ST_IDLE) && head.valid;

  always_comb begin
    match_found = 1'b0;
    match_idx   = '0;
    free_found  = 1'b0;
    free_idx    = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (chan_enabled[i] && (chan_pin[i] == head.item.pin)) begin
        match_found = 1'b1;
        match_idx   = CHAN_W'(i);
      end
      if (!chan_enabled[i]) begin
        free_found = 1'b1;
        free_idx   = CHAN_W'(i);
      end
    end
  end

  assign diff = tick_counter - chan_stamp[idx];
  assign prod = {16'd0, diff} * {32'd0, tick_period};

  assign elapsed = (s1_prod[47:32] != '0) ? 32'hFFFF_FFFF : s1_prod[31:0];

  always_comb begin
    s2_drive       = 1'b0;
    s2_drive_level = s1_level;
    s2_restamp     = 1'b0;
    s2_dec         = 1'b0;
    s2_set_phase   = 1'b0;
    s2_phase_next  = s1_phase;
    if (s1_valid && s1_enabled) begin
      if (s1_count == '0) begin
        s2_drive       = 1'b1;
        s2_drive_level = ~s1_level;
        s2_set_phase   = 1'b1;
        s2_phase_next  = PH_IDLE;
      end else begin
        unique case (s1_phase)
          PH_DRIVE_ON: begin
            s2_drive      = 1'b1;
            s2_restamp    = 1'b1;
            s2_set_phase  = 1'b1;
            s2_phase_next = PH_WAIT_ON;
          end
          PH_WAIT_ON: begin
            if ({16'd0, s1_on} <= elapsed) begin
              s2_drive       = 1'b1;
              s2_drive_level = ~s1_level;
              s2_restamp     = 1'b1;
              s2_set_phase   = 1'b1;
              s2_phase_next  = PH_WAIT_OFF;
            end
          end
          PH_WAIT_OFF: begin
            if ({16'd0, s1_off} <= elapsed) begin
              s2_dec        = 1'b1;
              s2_set_phase  = 1'b1;
              s2_phase_next = PH_DRIVE_ON;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_idx     <= idx;
    s1_pin     <= chan_pin[idx];
    s1_level   <= chan_level[idx];
    s1_count   <= chan_count[idx];
    s1_on      <= chan_on_time[idx];
    s1_off     <= chan_off_time[idx];
    s1_enabled <= chan_enabled[idx];
    s1_phase   <= chan_phase[idx];
    s1_prod    <= prod;

    if (s2_restamp) begin
      chan_stamp[s1_idx] <= tick_counter;
    end
    if (s2_dec) begin
      chan_count[s1_idx] <= s1_count - 16'd1;
    end
    if (s2_drive) begin
      hold_pin   <= s1_pin;
      hold_level <= s2_drive_level;
    end

    if (pop && (op_t'(head.item.op) == OP_START) && (match_found || free_found)) begin
      chan_pin[match_found ? match_idx : free_idx]      <= head.item.pin;
      chan_level[match_found ? match_idx : free_idx]    <= head.item.active_level;
      chan_count[match_found ? match_idx : free_idx]    <= head.item.repeat_count;
      chan_on_time[match_found ? match_idx : free_idx]  <= head.item.on_time;
      chan_off_time[match_found ? match_idx : free_idx] <= head.item.off_time;
    end
    if (pop && (op_t'(head.item.op) == OP_SET_COUNT) && match_found) begin
      chan_count[match_idx] <= head.item.repeat_count;
    end

    result <= '0;
    if (pop) begin
      result.last   <= 1'b1;
      result.status <= (op_t'(head.item.op) == OP_START) ? !(match_found || free_found)
                                                          : !match_found;
    end else if (s2_drive) begin
      result.drive_valid <= 1'b1;
      result.drive_pin   <= hold_pin;
      result.drive_level <= hold_level;
    end else if (state == ST_FLUSH) begin
      result.drive_valid <= 1'b1;
      result.drive_pin   <= hold_pin;
      result.drive_level <= hold_level;
      result.last        <= 1'b1;
    end

    if (rst) begin
      state        <= ST_IDLE;
      idx          <= '0;
      s1_valid     <= 1'b0;
      hold_valid   <= 1'b0;
      strobe       <= 1'b0;
      tick_counter <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        chan_enabled[i] <= 1'b0;
        chan_phase[i]   <= PH_IDLE;
      end
    end else begin
      strobe   <= 1'b0;
      s1_valid <= (state == ST_WALK);
      if (s2_set_phase) begin
        chan_phase[s1_idx] <= s2_phase_next;
      end
      if (s2_drive) begin
        hold_valid <= 1'b1;
        strobe     <= hold_valid;
      end
      unique case (state)
        ST_IDLE: begin
          idx <= '0;
          if (pop) begin
            if (op_t'(head.item.op) == OP_TICK) begin
              tick_counter <= tick_counter + 32'd1;
              state        <= ST_WALK;
            end else begin
              strobe <= 1'b1;
              if ((op_t'(head.item.op) == OP_START) && (match_found || free_found)) begin
                chan_enabled[match_found ? match_idx : free_idx] <= 1'b1;
                chan_phase[match_found ? match_idx : free_idx]   <= PH_DRIVE_ON;
              end
            end
          end
        end
        ST_WALK: begin
          if (idx == LAST_IDX) begin
            state <= ST_DRAIN;
          end else begin
            idx <= idx + CHAN_W'(1);
          end
        end
        ST_DRAIN: begin
          state <= ST_FLUSH;
        end
        ST_FLUSH: begin
          strobe     <= hold_valid;
          hold_valid <= 1'b0;
          state      <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == ST_IDLE))
    else $error("request taken while walking");
  a_drive_status_ok: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.drive_valid) |-> !result.status)
    else $error("drive result with error status");
  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.drive_valid) |-> result.last)
    else $error("lookup result not marked last");
  a_hold_empty_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !hold_valid && !s1_valid)
    else $error("walk left work behind");
`endif

endmodule

`default_nettype wire
